>>> hdl/atp_pkg.sv
`timescale 1ns / 1ps

package atp_pkg;

  // table and cpu geometry
  localparam int THREADS = 32;
  localparam int CPUS    = 4;
  localparam int PRIO_W  = 8;
  localparam int SLEEP_W = 16;
  localparam int SLOT_W  = $clog2(THREADS);
  localparam int CPU_W   = $clog2(CPUS);

  // request codes carried on the input tuser
  typedef enum logic [2:0] {
    ACT_LOAD      = 3'd0,
    ACT_SET_AFF   = 3'd1,
    ACT_SET_BLK   = 3'd2,
    ACT_SET_SLEEP = 3'd3,
    ACT_PICK      = 3'd4,
    ACT_READ      = 3'd5
  } action_e;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WRITE  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  // input tdata layout, lowest field at the bottom of the list
  typedef struct packed {
    logic [2:0]         pad;
    logic [CPU_W-1:0]   cpu_index;
    logic [15:0]        sleep_count;
    logic               blocked_flag;
    logic               sched_kind;
    logic [3:0]         affinity_mask;
    logic [7:0]         prio_value;
    logic [4:0]         slot;
  } in_data_t;

  // one thread table entry as kept in the slot ram
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [CPUS-1:0]    aff;
    logic               rr;
    logic               blocked;
    logic [SLEEP_W-1:0] sleep;
    logic               running;
  } slot_word_t;

  // pick context handed to the slot evaluator
  typedef struct packed {
    logic [CPU_W-1:0]   cpu;
    logic               clr_en;
    logic [SLOT_W-1:0]  clr_slot;
    logic               have;
    logic [PRIO_W-1:0]  best_prio;
  } pick_ctx_t;

  // evaluator result: entry to write back and whether it beats the best so far
  typedef struct packed {
    slot_word_t         word;
    logic               take;
  } slot_eval_t;

endpackage

>>> hdl/affinity_priority_thread_picker_core.sv
`timescale 1ns / 1ps
// load writes its slot in the accept cycle; set field reads the slot, then
// writes it back in ST_WRITE; a pick does one read-modify-write of the slot
// ram per entry over all 32 entries in ST_SCAN, then ST_COMMIT; pick and read
// current wait in ST_RESULT for a free output; input is taken only in ST_IDLE
// reset: slot valid bits and each cpu's current thread clear at once, no ram pass

module affinity_priority_thread_picker_core import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot, prio_value, affinity_mask, sched_kind, blocked_flag, sleep_count,
  // cpu_index, zero pad
  input  logic [39:0] s_axis_tdata,
  // action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_slot, zero pad
  output logic [7:0]  m_axis_tdata,
  // found
  output logic        m_axis_tuser
);

  state_e              state_q, state_d;
  in_data_t            in_d;
  action_e             in_act;
  logic                in_accept;

  in_data_t            req_q;
  action_e             act_q;
  logic [SLOT_W-1:0]   cnt_q;
  logic                have_q;
  logic [SLOT_W-1:0]   best_slot_q;
  logic [PRIO_W-1:0]   best_prio_q;
  slot_word_t          best_word_q;
  logic                clr_en_q;
  logic [SLOT_W-1:0]   clr_slot_q;
  logic [THREADS-1:0]  valid_q;
  logic [SLOT_W-1:0]   cur_slot_q [CPUS];
  logic [CPUS-1:0]     cur_valid_q;
  logic                m_valid_q;
  logic [SLOT_W-1:0]   m_slot_q;
  logic                m_found_q;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  slot_word_t          ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  slot_word_t          ram_rdata;

  pick_ctx_t           ctx;
  slot_eval_t          eval;
  logic                out_free;

  assign in_d          = in_data_t'(s_axis_tdata);
  assign in_act        = action_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = 8'(m_slot_q);
  assign m_axis_tuser  = m_found_q;

  // slot table storage
  atp_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (THREADS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // per-slot evaluation during the pick pass
  always_comb begin
    ctx.cpu       = req_q.cpu_index;
    ctx.clr_en    = clr_en_q;
    ctx.clr_slot  = clr_slot_q;
    ctx.have      = have_q;
    ctx.best_prio = best_prio_q;
  end

  atp_slot_eval u_eval (
    .word_i  (ram_rdata),
    .idx_i   (cnt_q),
    .valid_i (valid_q[cnt_q]),
    .ctx_i   (ctx),
    .eval_o  (eval)
  );

  // ram read address: next slot of the pass (slot 0 at a pick), else the addressed slot
  always_comb begin
    if (state_q == ST_SCAN) begin
      ram_raddr = cnt_q + SLOT_W'(1);
    end else if (in_act == ACT_PICK) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = in_d.slot;
    end
  end

  // ram write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = ram_rdata;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_act == ACT_LOAD)) begin
          ram_we            = 1'b1;
          ram_waddr         = in_d.slot;
          ram_wdata         = '0;
          ram_wdata.prio    = in_d.prio_value;
          ram_wdata.aff     = in_d.affinity_mask;
          ram_wdata.rr      = in_d.sched_kind;
        end
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = req_q.slot;
        case (act_q)
          ACT_SET_AFF: ram_wdata.aff     = req_q.affinity_mask;
          ACT_SET_BLK: ram_wdata.blocked = req_q.blocked_flag;
          default:     ram_wdata.sleep   = req_q.sleep_count;
        endcase
      end
      ST_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = eval.word;
      end
      ST_COMMIT: begin
        ram_we            = have_q;
        ram_waddr         = best_slot_q;
        ram_wdata         = best_word_q;
        ram_wdata.running = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_act)
            ACT_SET_AFF, ACT_SET_BLK, ACT_SET_SLEEP: state_d = ST_WRITE;
            ACT_PICK:                                state_d = ST_SCAN;
            ACT_READ:                                state_d = ST_RESULT;
            default:                                 state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:  state_d = ST_IDLE;
      ST_SCAN: begin
        if (cnt_q == SLOT_W'(THREADS - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      clr_en_q    <= 1'b0;
      valid_q     <= '0;
      cur_valid_q <= '0;
      m_valid_q   <= 1'b0;
      for (int c = 0; c < CPUS; c++) begin
        cur_slot_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;

      // request capture and pass setup
      if (in_accept) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
        if (in_act == ACT_LOAD) begin
          valid_q[in_d.slot] <= 1'b1;
        end
        clr_en_q <= cur_valid_q[in_d.cpu_index];
      end

      // pass over the table
      if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + SLOT_W'(1);
        if (eval.take) begin
          have_q <= 1'b1;
        end
      end

      // new current thread for the cpu
      if (state_q == ST_COMMIT) begin
        cur_valid_q[req_q.cpu_index] <= have_q;
        cur_slot_q[req_q.cpu_index]  <= have_q ? best_slot_q : '0;
      end

      // output register
      if (state_q == ST_RESULT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q      <= in_d;
      act_q      <= in_act;
      clr_slot_q <= cur_slot_q[in_d.cpu_index];
    end
    if (state_q == ST_SCAN && eval.take) begin
      best_slot_q <= cnt_q;
      best_prio_q <= eval.word.prio;
      best_word_q <= eval.word;
    end
    if (state_q == ST_RESULT && out_free) begin
      m_slot_q  <= cur_slot_q[req_q.cpu_index];
      m_found_q <= cur_valid_q[req_q.cpu_index];
    end
  end

endmodule

>>> hdl/atp_ram.sv
`timescale 1ns / 1ps

module atp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/atp_slot_eval.sv
`timescale 1ns / 1ps

module atp_slot_eval import atp_pkg::*; (
  input  slot_word_t        word_i,
  input  logic [SLOT_W-1:0] idx_i,
  input  logic              valid_i,
  input  pick_ctx_t         ctx_i,
  output slot_eval_t        eval_o
);

  logic               running_eff;
  logic               match;
  logic [SLEEP_W-1:0] sleep_new;
  logic               ready;

  // running mark of the cpu's previous thread is dropped during the pass
  assign running_eff = word_i.running & ~(ctx_i.clr_en && (ctx_i.clr_slot == idx_i));

  // eligible: loaded, priority-kind process, affinity allows this cpu
  assign match = valid_i && !word_i.rr && ((word_i.aff == '0) || word_i.aff[ctx_i.cpu]);

  // sleep ticks down once per pick for eligible slots
  assign sleep_new = (match && (word_i.sleep != '0)) ? word_i.sleep - SLEEP_W'(1)
                                                     : word_i.sleep;

  assign ready = match && !word_i.blocked && (sleep_new == '0) && !running_eff;

  // write-back entry and strict-less priority compare (first slot wins ties)
  always_comb begin
    eval_o.word         = word_i;
    eval_o.word.running = running_eff;
    eval_o.word.sleep   = sleep_new;
    eval_o.take         = ready && (!ctx_i.have || (word_i.prio < ctx_i.best_prio));
  end

endmodule

>>> hdl/atp_checker.sv
`timescale 1ns / 1ps

module atp_checker import atp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // no thread means slot reported as zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("nonzero slot with found low");

  // a load leaves the input ready in the following cycle
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD) |=> s_axis_tready)
    else $error("load transaction stalled the input");

  // a pick holds off the next transaction while the table is scanned
  a_pick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_PICK) |=> ##1 !s_axis_tready)
    else $error("input taken during pick pass");

endmodule

bind affinity_priority_thread_picker_core atp_checker u_atp_checker (.*);

>>> dv/affinity_priority_thread_picker_core_checker.sv
`timescale 1ns / 1ps

module affinity_priority_thread_picker_core_checker import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // slot, prio_value, affinity_mask, sched_kind, blocked_flag, sleep_count,
  // cpu_index, zero pad
  input  logic [39:0] s_axis_tdata,
  // action
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_slot, zero pad
  input  logic [7:0]  m_axis_tdata,
  // found
  input  logic        m_axis_tuser,
  output int          err_count_o,
  output int          owed_count_o
);

  // one pick or read answer
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } pick_result_t;

  // shadow thread table and per-cpu current thread
  logic               thr_valid   [THREADS];
  logic [PRIO_W-1:0]  thr_prio    [THREADS];
  logic [CPUS-1:0]    thr_aff     [THREADS];
  logic               thr_rr      [THREADS];
  logic               thr_blocked [THREADS];
  logic [SLEEP_W-1:0] thr_sleep   [THREADS];
  logic               thr_running [THREADS];
  logic [SLOT_W-1:0]  cpu_slot    [CPUS];
  logic               cpu_busy    [CPUS];

  pick_result_t owed_q[$];
  int           fault_total;

  // scan the table for one cpu, ticking sleep counts on the way
  function automatic pick_result_t pick_for_cpu(logic [CPU_W-1:0] cpu);
    pick_result_t      res;
    logic              have;
    logic [PRIO_W-1:0] best_prio;
    res       = '0;
    have      = 1'b0;
    best_prio = '0;
    if (cpu_busy[cpu]) thr_running[cpu_slot[cpu]] = 1'b0;
    for (int i = 0; i < THREADS; i++) begin
      if (thr_valid[i] && !thr_rr[i] && (thr_aff[i] == '0 || thr_aff[i][cpu])) begin
        if (thr_sleep[i] != '0) thr_sleep[i] = thr_sleep[i] - 1'b1;
        if (!thr_blocked[i] && thr_sleep[i] == '0 && !thr_running[i] &&
            (!have || thr_prio[i] < best_prio)) begin
          have      = 1'b1;
          best_prio = thr_prio[i];
          res.slot  = SLOT_W'(i);
        end
      end
    end
    res.found     = have;
    cpu_busy[cpu] = have;
    cpu_slot[cpu] = res.slot;
    if (have) thr_running[res.slot] = 1'b1;
    return res;
  endfunction

  // update the shadow table for one accepted request, queue any answer
  function automatic void apply_request(logic [2:0] act, in_data_t req);
    pick_result_t res;
    res = '0;
    case (act)
      ACT_LOAD: begin
        thr_valid[req.slot]   = 1'b1;
        thr_prio[req.slot]    = req.prio_value;
        thr_aff[req.slot]     = req.affinity_mask;
        thr_rr[req.slot]      = req.sched_kind;
        thr_blocked[req.slot] = 1'b0;
        thr_sleep[req.slot]   = '0;
        thr_running[req.slot] = 1'b0;
      end
      ACT_SET_AFF:   thr_aff[req.slot] = req.affinity_mask;
      ACT_SET_BLK:   thr_blocked[req.slot] = req.blocked_flag;
      ACT_SET_SLEEP: thr_sleep[req.slot] = req.sleep_count;
      ACT_PICK: begin
        res = pick_for_cpu(req.cpu_index);
        owed_q.push_back(res);
      end
      ACT_READ: begin
        res.found = cpu_busy[req.cpu_index];
        res.slot  = cpu_busy[req.cpu_index] ? cpu_slot[req.cpu_index] : '0;
        owed_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // compare each result transaction, then predict from each request transaction
  always @(posedge clk_i or negedge rst_ni) begin
    pick_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < THREADS; i++) begin
        thr_valid[i]   = 1'b0;
        thr_prio[i]    = '0;
        thr_aff[i]     = '0;
        thr_rr[i]      = 1'b0;
        thr_blocked[i] = 1'b0;
        thr_sleep[i]   = '0;
        thr_running[i] = 1'b0;
      end
      for (int c = 0; c < CPUS; c++) begin
        cpu_slot[c] = '0;
        cpu_busy[c] = 1'b0;
      end
      owed_q.delete();
      fault_total = 0;
      err_count_o  <= 0;
      owed_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: chosen_slot %0d found %0d",
                 m_axis_tdata[SLOT_W-1:0], m_axis_tuser);
          fault_total++;
        end else begin
          want = owed_q.pop_front();
          if (m_axis_tdata[SLOT_W-1:0] !== want.slot) begin
            $error("chosen_slot: expected %0d, actual %0d", want.slot,
                   m_axis_tdata[SLOT_W-1:0]);
            fault_total++;
          end
          if (m_axis_tuser !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, m_axis_tuser);
            fault_total++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tuser, s_axis_tdata);
      err_count_o  <= fault_total;
      owed_count_o <= owed_q.size();
    end
  end

endmodule

>>> dv/affinity_priority_thread_picker_core_test.sv
`timescale 1ns / 1ps

module affinity_priority_thread_picker_core_test;
  import atp_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int PHASES         = 5;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 50;

  // request codes the block leaves undefined
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // slot, prio_value, affinity_mask, sched_kind, blocked_flag, sleep_count,
  // cpu_index, zero pad
  logic [39:0] s_axis_tdata  = '0;
  // action
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // chosen_slot, zero pad
  logic [7:0]  m_axis_tdata;
  // found
  logic        m_axis_tuser;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int quiet_cycles    = 0;
  int err_count;
  int owed_count;

  // slots loaded at least once; only these take field updates
  logic [THREADS-1:0] ever_loaded = '0;

  affinity_priority_thread_picker_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  affinity_priority_thread_picker_core_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_count_o   (err_count),
    .owed_count_o  (owed_count)
  );

  always #5 clk_i = ~clk_i;

  // random backpressure on the result side
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // stop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("affinity_priority_thread_picker_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_data_t make_req(logic [SLOT_W-1:0] slot, logic [PRIO_W-1:0] prio,
                                        logic [3:0] aff, logic kind, logic blk,
                                        logic [15:0] sleep, logic [CPU_W-1:0] cpu);
    in_data_t d;
    d               = '0;
    d.slot          = slot;
    d.prio_value    = prio;
    d.affinity_mask = aff;
    d.sched_kind    = kind;
    d.blocked_flag  = blk;
    d.sleep_count   = sleep;
    d.cpu_index     = cpu;
    return d;
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic push_request(logic [2:0] act, in_data_t d);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_LOAD) ever_loaded[d.slot] = 1'b1;
  endtask

  // hold off until every owed answer has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
  endtask

  // mostly well-formed table traffic with random content
  task automatic random_request(output bit counted);
    int          roll;
    logic [2:0]  act;
    logic [15:0] sleep;
    logic [7:0]  prio;
    logic [3:0]  aff;
    in_data_t    d;
    roll  = $urandom_range(99);
    prio  = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    aff   = ($urandom_range(9) < 3) ? 4'd0 : 4'($urandom_range(15));
    sleep = 16'($urandom_range(99));
    if (sleep < 70) sleep = 16'($urandom_range(3));
    else if (sleep < 90) sleep = 16'($urandom_range(40, 4));
    else sleep = 16'($urandom_range(16'hFFFF));
    d = make_req(SLOT_W'($urandom_range(THREADS - 1)), prio, aff, $urandom_range(99) < 20,
                 $urandom_range(99) < 35, sleep, CPU_W'($urandom_range(CPUS - 1)));
    if (roll < 15) act = ACT_LOAD;
    else if (roll < 25) act = ACT_SET_AFF;
    else if (roll < 38) act = ACT_SET_BLK;
    else if (roll < 50) act = ACT_SET_SLEEP;
    else if (roll < 82) act = ACT_PICK;
    else if (roll < 94) act = ACT_READ;
    else if (roll < 97) act = ACT_RSVD6;
    else act = ACT_RSVD7;
    // field updates and undefined codes go to loaded slots only
    if (act != ACT_LOAD && act != ACT_PICK && act != ACT_READ)
      while (!ever_loaded[d.slot]) d.slot = SLOT_W'($urandom_range(THREADS - 1));
    counted = (act != ACT_RSVD6 && act != ACT_RSVD7);
    push_request(act, d);
  endtask

  initial begin
    int count;
    bit counted;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, round robin, blocked, sleep, ties
    push_request(ACT_READ,      make_req(0, 0, 0, 0, 0, 0, 0));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 1));
    push_request(ACT_LOAD,      make_req(0, 255, 4'h0, 0, 0, 0, 0));
    push_request(ACT_LOAD,      make_req(31, 0, 4'h8, 0, 0, 0, 0));
    push_request(ACT_LOAD,      make_req(5, 0, 4'h1, 1, 0, 0, 0));
    push_request(ACT_LOAD,      make_req(7, 10, 4'h2, 0, 0, 0, 0));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 3));
    push_request(ACT_READ,      make_req(0, 0, 0, 0, 0, 0, 3));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 0));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 1));
    push_request(ACT_SET_BLK,   make_req(7, 0, 0, 0, 1, 0, 0));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 1));
    push_request(ACT_READ,      make_req(0, 0, 0, 0, 0, 0, 1));
    push_request(ACT_SET_BLK,   make_req(7, 0, 0, 0, 0, 0, 0));
    push_request(ACT_SET_SLEEP, make_req(7, 0, 0, 0, 0, 2, 0));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 1));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 1));
    push_request(ACT_SET_SLEEP, make_req(0, 0, 0, 0, 0, 16'hFFFF, 0));
    push_request(ACT_SET_AFF,   make_req(31, 0, 4'hF, 0, 0, 0, 0));
    push_request(ACT_LOAD,      make_req(16, 10, 4'h0, 0, 0, 0, 0));
    push_request(ACT_LOAD,      make_req(20, 10, 4'h0, 0, 0, 0, 0));
    push_request(ACT_PICK,      make_req(0, 0, 0, 0, 0, 0, 2));
    push_request(ACT_RSVD6,     make_req(0, 0, 0, 0, 0, 0, 0));
    push_request(ACT_RSVD7,     make_req(31, 255, 4'hF, 1, 1, 16'hFFFF, 3));
    push_request(ACT_READ,      make_req(0, 0, 0, 0, 0, 0, 2));
    wait_drained();

    // random phases with different idle and stall mixes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       begin sender_idle_pct = 85; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 85; end
        3:       begin sender_idle_pct = 35; stall_pct = 35; end
        default: begin sender_idle_pct = 0;  stall_pct = 0;  end
      endcase
      count = 0;
      while (count < RANDOM_ITEMS / PHASES) begin
        random_request(counted);
        if (counted) count++;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("affinity_priority_thread_picker_core_test: done, clean");
    end else begin
      $display("affinity_priority_thread_picker_core_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/atp_pkg.sv
hdl/atp_ram.sv
hdl/atp_slot_eval.sv
hdl/affinity_priority_thread_picker_core.sv
hdl/atp_checker.sv
dv/affinity_priority_thread_picker_core_checker.sv
dv/affinity_priority_thread_picker_core_test.sv
